### hw/rtl/llq_pkg.sv
// Package for the linked-list queue: command and result types, status codes.
// Used by llq_front, llq_back, the top level and llq_chk; depends on nothing.
`timescale 1ns / 1ps
package llq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_FULL,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] item_byte;
  } cmd_t;

  // Packed from the top down, so status lands in the lowest bits of tdata.
  typedef struct packed {
    logic       is_empty;
    logic [4:0] occupancy;
    logic [7:0] tail_byte;
    logic [7:0] head_byte;
    logic [7:0] removed_byte;
    logic [1:0] status;
  } res_t;

endpackage

### hw/rtl/llq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module llq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/llq_fifo.sv
// Two-entry command queue between the classifier and the execution engine.
// Depends on nothing.
`timescale 1ns / 1ps
module llq_fifo #(
  parameter int WIDTH = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

endmodule

### hw/rtl/llq_front.sv
// Front end: accepts items and classifies them against a running count.
// Depends on llq_pkg.
`timescale 1ns / 1ps
module llq_front #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_tuser,
  input  logic [7:0]    in_tdata,
  input  logic          q_full,
  output logic          q_push,
  output llq_pkg::cmd_t q_cmd
);
  import llq_pkg::*;

  localparam int CW = $clog2(SLOTS + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          take;

  assign in_tready = en && !q_full;
  assign take      = in_tvalid && in_tready;
  assign q_push    = take;

  always_comb begin
    cnt_nxt         = cnt_r;
    q_cmd.item_byte = in_tdata;
    if (in_tuser == OP_ENQ) begin
      if (cnt_r == CW'(SLOTS)) begin
        q_cmd.kind = CMD_FULL;
      end else begin
        q_cmd.kind = CMD_ENQ;
        if (take) begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end else begin
      if (cnt_r == '0) begin
        q_cmd.kind = CMD_EMPTY;
      end else begin
        q_cmd.kind = CMD_DEQ;
        if (take) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hw/rtl/llq_back.sv
// Execution engine: link and byte memories, queue pointers and result register.
// Depends on llq_pkg and llq_ram.
`timescale 1ns / 1ps
module llq_back #(
  parameter int SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          init_done,
  input  logic          q_valid,
  input  llq_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output llq_pkg::res_t out_res
);
  import llq_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ENQ,
    S_DEQ,
    S_DEQ_HEAD
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] ic_r, ic_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    head_r, head_nxt;
  logic [7:0]    tail_r, tail_nxt;
  logic [7:0]    removed_r, removed_nxt;
  res_t          res_r, res_nxt;
  logic          ov_r, ov_nxt;
  logic          emit;
  logic [1:0]    emit_status;
  logic          empty_nxt;

  logic          lk_we;
  logic [AW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic          bs_we;
  logic [AW-1:0] bs_waddr, bs_raddr;
  logic [7:0]    bs_wdata, bs_rdata;

  llq_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_link (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  llq_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_bytes (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (bs_wdata),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    ic_nxt      = ic_r;
    free_nxt    = free_r;
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    cnt_nxt     = cnt_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    removed_nxt = removed_r;
    res_nxt     = res_r;
    ov_nxt      = ov_r && !out_tready;
    emit        = 1'b0;
    emit_status = ST_DONE;
    q_pop       = 1'b0;
    lk_we       = 1'b0;
    lk_waddr    = rear_r;
    lk_wdata    = free_r;
    lk_raddr    = free_r;
    bs_we       = 1'b0;
    bs_waddr    = free_r;
    bs_wdata    = q_cmd.item_byte;
    bs_raddr    = lk_rdata;

    unique case (state_r)
      S_INIT: begin
        lk_we    = 1'b1;
        lk_waddr = ic_r;
        lk_wdata = ic_r + AW'(1);
        ic_nxt   = ic_r + AW'(1);
        if (ic_r == AW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && (!ov_r || out_tready)) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            CMD_ENQ: begin
              bs_we = 1'b1;
              if (cnt_r != '0) begin
                lk_we = 1'b1;
              end else begin
                front_nxt = free_r;
                head_nxt  = q_cmd.item_byte;
              end
              rear_nxt    = free_r;
              tail_nxt    = q_cmd.item_byte;
              cnt_nxt     = cnt_r + CW'(1);
              removed_nxt = 8'd0;
              state_nxt   = S_ENQ;
            end
            CMD_DEQ: begin
              lk_raddr    = front_r;
              removed_nxt = head_r;
              cnt_nxt     = cnt_r - CW'(1);
              state_nxt   = S_DEQ;
            end
            CMD_FULL: begin
              removed_nxt = 8'd0;
              emit_status = ST_FULL;
              emit        = 1'b1;
            end
            CMD_EMPTY: begin
              removed_nxt = 8'd0;
              emit_status = ST_EMPTY;
              emit        = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_ENQ: begin
        free_nxt  = lk_rdata;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DEQ: begin
        lk_we    = 1'b1;
        lk_waddr = front_r;
        lk_wdata = free_r;
        free_nxt = front_r;
        if (cnt_r == '0) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          front_nxt = lk_rdata;
          state_nxt = S_DEQ_HEAD;
        end
      end
      S_DEQ_HEAD: begin
        head_nxt  = bs_rdata;
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    empty_nxt = (cnt_nxt == '0);
    if (emit) begin
      ov_nxt               = 1'b1;
      res_nxt.status       = emit_status;
      res_nxt.removed_byte = removed_nxt;
      res_nxt.head_byte    = empty_nxt ? 8'd0 : head_nxt;
      res_nxt.tail_byte    = empty_nxt ? 8'd0 : tail_nxt;
      res_nxt.occupancy    = 5'(32'(cnt_nxt));
      res_nxt.is_empty     = empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ic_r    <= '0;
      free_r  <= '0;
      front_r <= '0;
      rear_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ic_r    <= ic_nxt;
      free_r  <= free_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    removed_r <= removed_nxt;
    res_r     <= res_nxt;
  end

  assign init_done  = (state_r != S_INIT);
  assign out_tvalid = ov_r;
  assign out_res    = res_r;

endmodule

### hw/rtl/linked_list_queue_with_free_list.sv
// Top level of the linked-list byte queue with a free list of slots.
// Depends on llq_pkg, llq_front, llq_fifo and llq_back.
//
// Channel  Ports      Payload
// input    in_*       tuser: op; tdata: item_byte
// result   out_*      tdata: status, removed_byte, head_byte, tail_byte, occupancy, is_empty
//
// The engine passes an enqueue through S_ENQ and a dequeue through S_DEQ and, unless that
// empties the queue, S_DEQ_HEAD, as the link and byte memories have registered reads.
// After reset the engine writes the initial links with in_tready low.
// A two-entry command queue lets the input side accept up to two items while results stall.
// Each result waits in an output register until out_tready takes it.
`timescale 1ns / 1ps
module linked_list_queue_with_free_list #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // [0] op
  input  logic [7:0]  in_tdata,   // [7:0] item_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [1:0] status, [9:2] removed_byte, [17:10] head_byte,
                                  // [25:18] tail_byte, [30:26] occupancy, [31] is_empty
);
  import llq_pkg::*;

  logic init_done;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t push_cmd, pop_cmd;
  res_t res;

  llq_front #(.SLOTS(SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (init_done),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  llq_fifo #(.WIDTH($bits(cmd_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (pop_cmd),
    .valid (q_valid)
  );

  llq_back #(.SLOTS(SLOTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_done  (init_done),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res;

endmodule

### hw/rtl/llq_chk.sv
// Port-level checks for the linked-list queue, bound to the top level.
// Depends on llq_pkg and linked_list_queue_with_free_list.
`timescale 1ns / 1ps
module llq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import llq_pkg::*;

  res_t r;
  assign r = out_tdata;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.is_empty |-> r.occupancy == 5'd0 && r.head_byte == 8'd0
      && r.tail_byte == 8'd0)
    else $error("Empty queue reported with contents.");

  a_rej_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.status == ST_EMPTY |-> r.is_empty && r.removed_byte == 8'd0)
    else $error("Dequeue rejected on a non-empty queue.");

  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.status == ST_FULL |-> !r.is_empty && r.removed_byte == 8'd0)
    else $error("Enqueue rejected on an empty queue.");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> r.status == ST_DONE || r.status == ST_FULL || r.status == ST_EMPTY)
    else $error("Unknown status code.");

endmodule

bind linked_list_queue_with_free_list llq_chk u_chk (.*);
